// ===== rtl/stoi_pkg.sv =====
package stoi_pkg;

   localparam int MAX_SYMBOLS_DEF = 16;
   localparam int SYM_W           = 8;
   localparam int SYM_IDX_W       = 4;
   localparam int LEN_W           = 5;
   localparam int CFG_W           = 64;
   localparam int CSR_IDX_W       = 2;
   localparam int VALUE_W         = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_LO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_HI = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd2;

   // Character codes
   localparam logic [SYM_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [SYM_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [SYM_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [SYM_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

   // Parser phases
   localparam logic [1:0] PH_SPACE = 2'd0;
   localparam logic [1:0] PH_SIGN  = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   typedef struct packed {
      logic                 hit;
      logic [SYM_IDX_W-1:0] index;
   } match_type;

   typedef struct packed {
      logic                      emit;
      logic signed [VALUE_W-1:0] value;
      logic                      base_ok;
   } result_type;

endpackage

// ===== rtl/stoi_alphabet.sv =====
module stoi_alphabet #(
   parameter int MAX_SYMBOLS = stoi_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [stoi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stoi_pkg::CFG_W-1:0]           csr_data,
   input  logic [stoi_pkg::SYM_W-1:0]           character,
   output logic [stoi_pkg::LEN_W-1:0]           base_length,
   output logic                                 base_ok,
   output stoi_pkg::match_type                  match
);

   logic [stoi_pkg::CFG_W-1:0]     sym_lo_ff;
   logic [stoi_pkg::CFG_W-1:0]     sym_hi_ff;
   logic [stoi_pkg::LEN_W-1:0]     len_ff;
   logic [2*stoi_pkg::CFG_W-1:0]   sym_all;
   logic [stoi_pkg::SYM_W-1:0]     sym [MAX_SYMBOLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_lo_ff <= '0;
         sym_hi_ff <= '0;
         len_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            stoi_pkg::CSR_SYM_LO: sym_lo_ff <= csr_data;
            stoi_pkg::CSR_SYM_HI: sym_hi_ff <= csr_data;
            stoi_pkg::CSR_LENGTH: len_ff    <= csr_data[stoi_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign sym_all     = {sym_hi_ff, sym_lo_ff};
   assign base_length = len_ff;

   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         sym[k] = sym_all[stoi_pkg::SYM_W*k +: stoi_pkg::SYM_W];
      end
   end

   // Alphabet check: length in range, every used symbol in 33..127 and no sign,
   // no symbol repeated
   always_comb begin
      base_ok = (len_ff >= stoi_pkg::LEN_W'(2)) &&
                (len_ff <= stoi_pkg::LEN_W'(MAX_SYMBOLS));
      for (int a = 0; a < MAX_SYMBOLS; a++) begin
         if (stoi_pkg::LEN_W'(a) < len_ff) begin
            if (sym[a] == stoi_pkg::CHAR_PLUS || sym[a] == stoi_pkg::CHAR_MINUS ||
                sym[a] <= stoi_pkg::CHAR_SPACE || sym[a][stoi_pkg::SYM_W-1]) begin
               base_ok = 1'b0;
            end
            for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
               if (stoi_pkg::LEN_W'(b) < len_ff && sym[a] == sym[b]) begin
                  base_ok = 1'b0;
               end
            end
         end
      end
   end

   // First matching symbol wins: scan from the top so lower indexes override
   always_comb begin
      match = '0;
      for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
         if (stoi_pkg::LEN_W'(k) < len_ff && sym[k] == character) begin
            match.hit   = 1'b1;
            match.index = stoi_pkg::SYM_IDX_W'(k);
         end
      end
   end

endmodule

// ===== rtl/stoi_parser.sv =====
module stoi_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [stoi_pkg::SYM_W-1:0]      character,
   input  stoi_pkg::match_type             match,
   input  logic [stoi_pkg::LEN_W-1:0]      base_length,
   input  logic                            base_ok,
   output stoi_pkg::result_type            result
);

   logic [1:0]                     phase_ff;
   logic [1:0]                     phase_in;
   logic                           negative_ff;
   logic                           negative_in;
   logic [stoi_pkg::VALUE_W-1:0]   acc_ff;
   logic [stoi_pkg::VALUE_W-1:0]   acc_in;
   logic [stoi_pkg::VALUE_W-1:0]   acc_next;
   logic                           is_space;
   logic                           is_sign;

   assign is_space = character inside {stoi_pkg::CHAR_SPACE,
                                       [stoi_pkg::CHAR_TAB:stoi_pkg::CHAR_CR]};
   assign is_sign  = (character == stoi_pkg::CHAR_PLUS) ||
                     (character == stoi_pkg::CHAR_MINUS);
   assign acc_next = stoi_pkg::VALUE_W'(acc_ff * stoi_pkg::VALUE_W'(base_length)) +
                     stoi_pkg::VALUE_W'(match.index);

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      if (fire) begin
         if (character == stoi_pkg::CHAR_NUL) begin
            phase_in    = stoi_pkg::PH_SPACE;
            negative_in = 1'b0;
            acc_in      = '0;
         end else if (phase_ff == stoi_pkg::PH_DONE) begin
            // drop trailing bytes
         end else if (phase_ff == stoi_pkg::PH_SPACE && is_space) begin
            // skip leading white space
         end else if ((phase_ff == stoi_pkg::PH_SPACE || phase_ff == stoi_pkg::PH_SIGN) &&
                      is_sign) begin
            phase_in = stoi_pkg::PH_SIGN;
            if (character == stoi_pkg::CHAR_MINUS) begin
               negative_in = ~negative_ff;
            end
         end else if (match.hit) begin
            phase_in = stoi_pkg::PH_DIGIT;
            acc_in   = acc_next;
         end else begin
            phase_in = stoi_pkg::PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= stoi_pkg::PH_SPACE;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
      end
   end

   always_comb begin
      result.emit    = fire && (character == stoi_pkg::CHAR_NUL);
      result.base_ok = base_ok;
      if (!base_ok) begin
         result.value = '0;
      end else if (negative_ff) begin
         result.value = $signed(-acc_ff);
      end else begin
         result.value = $signed(acc_ff);
      end
   end

endmodule

// ===== rtl/string_to_integer_any_base_unit.sv =====
// String-to-integer converter with a programmable digit alphabet. Feed one byte
// of a NUL-terminated string per transaction on req_; the NUL byte returns one
// transaction on rsp_ with the signed value (wrapped modulo 2^32) and base_ok.
// Leading white space is skipped, a run of '+'/'-' sets the sign (each '-' flips
// it), and digits accumulate as value * base + index until the first non-digit;
// later bytes are dropped. A byte enters every cycle unless stalled: it lands
// in an input register, the alphabet compare and the 32x5 multiply-add run in
// the next cycle, and a NUL loads its result into the result register on rsp_.
// The input stalls only when a NUL sits in the input register while a previous
// result is still held on rsp_. Load the alphabet via csr_ (index 0: symbols 0..7,
// index 1: symbols 8..15, index 2: length) only while no transaction is in
// flight; a string already under way continues with the new alphabet.
module string_to_integer_any_base_unit #(
   parameter int MAX_SYMBOLS = stoi_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [stoi_pkg::SYM_W-1:0]           req_character,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [stoi_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                 rsp_base_ok,
   input  logic                                 csr_write_enable,
   input  logic [stoi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stoi_pkg::CFG_W-1:0]           csr_data
);

   // Input register
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [stoi_pkg::SYM_W-1:0]        in_char_ff;
   // Result register
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [stoi_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                              rsp_base_ok_ff;

   logic                              accept;
   logic                              advance;
   logic                              rsp_free;
   logic [stoi_pkg::LEN_W-1:0]        base_length;
   logic                              base_ok;
   stoi_pkg::match_type               match;
   stoi_pkg::result_type              result;

   // A NUL needs a free result slot; any other byte only updates the parser
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (in_char_ff != stoi_pkg::CHAR_NUL || rsp_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_character;
      end
   end

   stoi_alphabet #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_alphabet (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .character        (in_char_ff),
      .base_length      (base_length),
      .base_ok          (base_ok),
      .match            (match)
   );

   stoi_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .character   (in_char_ff),
      .match       (match),
      .base_length (base_length),
      .base_ok     (base_ok),
      .result      (result)
   );

   // Hold the result until taken; load a new one when a NUL goes through
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         rsp_value_ff   <= result.value;
         rsp_base_ok_ff <= result.base_ok;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_base_ok = rsp_base_ok_ff;

endmodule

// ===== rtl/stoi_checker.sv =====
module stoi_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [stoi_pkg::SYM_W-1:0]           req_character,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [stoi_pkg::VALUE_W-1:0]  rsp_value,
   input  logic                                 rsp_base_ok
);

   // A held result keeps its payload
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_base_ok);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp payload changed while stalled");

   // Bad alphabet always reports zero
   property p_bad_base_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_base_ok |-> rsp_value == '0;
   endproperty
   a_bad_base_zero: assert property (p_bad_base_zero) else $error("nonzero value on bad alphabet");

   // Reset empties both registers
   property p_reset_clear;
      @(posedge clock) reset |=> !rsp_valid && !req_stall;
   endproperty
   a_reset_clear: assert property (p_reset_clear) else $error("state not cleared by reset");

   // A non-NUL byte never blocks the byte behind it
   property p_no_stall_after_byte;
      @(posedge clock)
         req_valid && !req_stall && req_character != stoi_pkg::CHAR_NUL |=> !req_stall;
   endproperty
   a_no_stall_after_byte: assert property (p_no_stall_after_byte)
      else $error("input stalled behind a non-NUL byte");

endmodule

bind string_to_integer_any_base_unit stoi_checker u_stoi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_character (req_character),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_value     (rsp_value),
   .rsp_base_ok   (rsp_base_ok)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   // Index that decodes to no register; writes to it must change nothing
   localparam logic [stoi_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES     = 6;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int NUM_SETTINGS      = 12;
   localparam int BYTES_PER_SETTING = 65;

   typedef enum int {
      FAULT_NONE,
      FAULT_SIGN,
      FAULT_LOW_BYTE,
      FAULT_HIGH_BYTE,
      FAULT_DUPLICATE
   } alphabet_fault_type;

   typedef struct {
      logic signed [stoi_pkg::VALUE_W-1:0] value;
      logic                                base_ok;
   } parsed_number_type;

   class atoi_scoreboard;
      logic [stoi_pkg::CFG_W-1:0]   sym_lo;
      logic [stoi_pkg::CFG_W-1:0]   sym_hi;
      logic [stoi_pkg::LEN_W-1:0]   base_len;
      logic [1:0]                   phase;
      bit                           negative;
      logic [stoi_pkg::VALUE_W-1:0] acc;
      parsed_number_type            awaited[$];
      int                           mismatches;
      int                           numbers_checked;

      function new();
         sym_lo          = '0;
         sym_hi          = '0;
         base_len        = '0;
         phase           = stoi_pkg::PH_SPACE;
         negative        = 1'b0;
         acc             = '0;
         mismatches      = 0;
         numbers_checked = 0;
      endfunction

      function void write_reg(logic [stoi_pkg::CSR_IDX_W-1:0] idx,
                              logic [stoi_pkg::CFG_W-1:0] data);
         case (idx)
            stoi_pkg::CSR_SYM_LO: sym_lo = data;
            stoi_pkg::CSR_SYM_HI: sym_hi = data;
            stoi_pkg::CSR_LENGTH: base_len = data[stoi_pkg::LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [stoi_pkg::SYM_W-1:0] symbol(int k);
         if (k < 8) return sym_lo[8*k +: 8];
         return sym_hi[8*(k-8) +: 8];
      endfunction

      function bit alphabet_valid();
         logic [stoi_pkg::SYM_W-1:0] s;
         if (base_len < 2 || base_len > stoi_pkg::MAX_SYMBOLS_DEF) return 1'b0;
         for (int a = 0; a < int'(base_len); a++) begin
            s = symbol(a);
            if (s == stoi_pkg::CHAR_PLUS || s == stoi_pkg::CHAR_MINUS ||
                s <= stoi_pkg::CHAR_SPACE || s[7]) return 1'b0;
            for (int b = a + 1; b < int'(base_len); b++)
               if (symbol(b) == s) return 1'b0;
         end
         return 1'b1;
      endfunction

      function int digit_index(logic [stoi_pkg::SYM_W-1:0] ch);
         int n;
         n = (base_len > stoi_pkg::MAX_SYMBOLS_DEF) ? stoi_pkg::MAX_SYMBOLS_DEF
                                                    : int'(base_len);
         for (int k = 0; k < n; k++)
            if (symbol(k) == ch) return k;
         return -1;
      endfunction

      function void note_byte(logic [stoi_pkg::SYM_W-1:0] ch);
         parsed_number_type r;
         int d;
         if (ch == stoi_pkg::CHAR_NUL) begin
            r.base_ok = alphabet_valid();
            r.value   = r.base_ok ? (negative ? -acc : acc) : '0;
            awaited.push_back(r);
            phase    = stoi_pkg::PH_SPACE;
            negative = 1'b0;
            acc      = '0;
            return;
         end
         if (phase == stoi_pkg::PH_DONE) return;
         if (phase == stoi_pkg::PH_SPACE &&
             (ch == stoi_pkg::CHAR_SPACE ||
              (ch >= stoi_pkg::CHAR_TAB && ch <= stoi_pkg::CHAR_CR))) return;
         if (phase <= stoi_pkg::PH_SIGN &&
             (ch == stoi_pkg::CHAR_PLUS || ch == stoi_pkg::CHAR_MINUS)) begin
            if (ch == stoi_pkg::CHAR_MINUS) negative = !negative;
            phase = stoi_pkg::PH_SIGN;
            return;
         end
         d = digit_index(ch);
         if (d >= 0) begin
            acc   = acc * 32'(base_len) + 32'(d);
            phase = stoi_pkg::PH_DIGIT;
         end else begin
            phase = stoi_pkg::PH_DONE;
         end
      endfunction

      function void check_result(logic signed [stoi_pkg::VALUE_W-1:0] value, logic base_ok);
         parsed_number_type e;
         if (awaited.size() == 0) begin
            $error("unexpected result: value %0d base_ok %0b", value, base_ok);
            mismatches++;
            return;
         end
         e = awaited.pop_front();
         numbers_checked++;
         if (value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, value);
            mismatches++;
         end
         if (base_ok !== e.base_ok) begin
            $error("base_ok: expected %0b, got %0b", e.base_ok, base_ok);
            mismatches++;
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [stoi_pkg::SYM_W-1:0]          req_character;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [stoi_pkg::VALUE_W-1:0] rsp_value;
   logic                                rsp_base_ok;
   logic                                csr_write_enable;
   logic [stoi_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [stoi_pkg::CFG_W-1:0]          csr_data;

   atoi_scoreboard board;

   // Alphabet staged for the next load; string generation draws digits from it
   logic [stoi_pkg::SYM_W-1:0] alpha [16];
   int                         idle_pct;
   int                         stall_pct;
   int                         bytes_sent;
   int                         strings_sent;

   string_to_integer_any_base_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_character    (req_character),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_base_ok      (rsp_base_ok),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Send one byte; optionally idle first, then hold it until the transaction
   // completes. Outputs are sampled right after the edge, before any update.
   task automatic send_byte(input logic [stoi_pkg::SYM_W-1:0] ch);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(ch);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k]);
   endtask

   // Drop valid, wait for every pending result, then let the pipeline settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Build an alphabet of n distinct legal symbols, garbage in the unused
   // slots, and optionally break it in one of the ways that make it invalid.
   task automatic make_alphabet(input int n, input alphabet_fault_type fault);
      bit                         taken [256];
      logic [stoi_pkg::SYM_W-1:0] s;
      int                         p;
      int                         q;
      for (int k = 0; k < 256; k++) taken[k] = 1'b0;
      for (int k = 0; k < 16; k++) begin
         if (k < n) begin
            do s = 8'($urandom_range(33, 127));
            while (taken[s] || s == stoi_pkg::CHAR_PLUS || s == stoi_pkg::CHAR_MINUS);
            taken[s] = 1'b1;
            alpha[k] = s;
         end else begin
            alpha[k] = 8'($urandom_range(0, 255));
         end
      end
      p = $urandom_range(0, n - 1);
      case (fault)
         FAULT_SIGN:      alpha[p] = $urandom_range(0, 1) ? stoi_pkg::CHAR_PLUS
                                                          : stoi_pkg::CHAR_MINUS;
         FAULT_LOW_BYTE:  alpha[p] = 8'($urandom_range(0, 32));
         FAULT_HIGH_BYTE: alpha[p] = 8'($urandom_range(128, 255));
         FAULT_DUPLICATE: begin
            do q = $urandom_range(0, n - 1); while (q == p);
            alpha[p] = alpha[q];
         end
         default: ;
      endcase
   endtask

   task automatic fill_hex_digits();
      string digits;
      digits = "0123456789ABCDEF";
      for (int k = 0; k < 16; k++) alpha[k] = digits[k];
   endtask

   // Load the staged alphabet once the block is idle. The length write carries
   // random upper bits, which the block must ignore.
   task automatic program_alphabet(input logic [stoi_pkg::LEN_W-1:0] len,
                                   input bit poke_unused);
      logic [stoi_pkg::CSR_IDX_W-1:0] idx [4];
      logic [stoi_pkg::CFG_W-1:0]     val [4];
      int                             count;
      count = 0;
      for (int k = 0; k < 4; k++) val[k] = '0;
      if (poke_unused) begin
         idx[0] = CSR_UNUSED;
         val[0] = {$urandom, $urandom};
         count  = 1;
      end
      idx[count]   = stoi_pkg::CSR_SYM_LO;
      idx[count+1] = stoi_pkg::CSR_SYM_HI;
      for (int k = 0; k < 8; k++) begin
         val[count][8*k +: 8]   = alpha[k];
         val[count+1][8*k +: 8] = alpha[k+8];
      end
      idx[count+2]                     = stoi_pkg::CSR_LENGTH;
      val[count+2]                     = {$urandom, $urandom};
      val[count+2][stoi_pkg::LEN_W-1:0] = len;
      count += 3;
      drain_results();
      for (int k = 0; k < count; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[k];
         csr_data         <= val[k];
         @(posedge clock);
         board.write_reg(idx[k], val[k]);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [stoi_pkg::SYM_W-1:0] random_blank();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? stoi_pkg::CHAR_SPACE : stoi_pkg::CHAR_TAB + 8'(r);
   endfunction

   // Mostly well-formed strings: blanks, a sign run, digits, an optional tail.
   // The rest are broken sequences and plain noise. Every string ends in NUL.
   task automatic send_string(input logic [stoi_pkg::LEN_W-1:0] len);
      int n;
      int shape;
      n = (len > stoi_pkg::MAX_SYMBOLS_DEF) ? stoi_pkg::MAX_SYMBOLS_DEF : int'(len);
      if (n < 2) n = stoi_pkg::MAX_SYMBOLS_DEF;
      shape = $urandom_range(0, 9);
      if (shape < 8) begin
         repeat ($urandom_range(0, 3)) send_byte(random_blank());
         repeat ($urandom_range(0, 3))
            send_byte($urandom_range(0, 1) ? stoi_pkg::CHAR_MINUS : stoi_pkg::CHAR_PLUS);
         repeat ($urandom_range(1, 12)) send_byte(alpha[$urandom_range(0, n - 1)]);
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
      end else if (shape == 8) begin
         // blank or sign in the wrong place ends the number
         send_byte($urandom_range(0, 1) ? stoi_pkg::CHAR_MINUS : stoi_pkg::CHAR_PLUS);
         if ($urandom_range(0, 1)) send_byte(random_blank());
         else send_byte(alpha[$urandom_range(0, n - 1)]);
         send_byte($urandom_range(0, 1) ? stoi_pkg::CHAR_MINUS : random_blank());
         send_byte(alpha[$urandom_range(0, n - 1)]);
      end else begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(1, 255)));
      end
      send_byte(stoi_pkg::CHAR_NUL);
      strings_sent++;
      // now and then hold the sender until every result is back
      if ($urandom_range(0, 24) == 0) drain_results();
   endtask

   task automatic set_idle_mix(input int mix);
      case (mix)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 45; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 45; end
         default: begin idle_pct = 18; stall_pct = 18; end
      endcase
   endtask

   // Result side: check every completed transaction, then pick the next stall
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_value, rsp_base_ok);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      logic [stoi_pkg::LEN_W-1:0] len;
      int                         target;
      board            = new();
      idle_pct         = 0;
      stall_pct        = 0;
      bytes_sent       = 0;
      strings_sent     = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_character    <= stoi_pkg::CHAR_NUL;
      csr_write_enable <= 1'b0;
      csr_index        <= stoi_pkg::CSR_SYM_LO;
      csr_data         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: decimal alphabet, blanks, a sign run that cancels out,
      // a non-digit ending the number with trailing bytes ignored
      fill_hex_digits();
      program_alphabet(5'd10, 1'b1);
      send_text("\011\015 +-+-7x9");
      send_byte(stoi_pkg::CHAR_NUL);
      // blank after a sign ends parsing
      send_text("-\0135");
      send_byte(stoi_pkg::CHAR_NUL);
      // top byte value, then an empty string
      send_byte(8'hFF);
      send_text("1");
      send_byte(stoi_pkg::CHAR_NUL);
      send_byte(stoi_pkg::CHAR_NUL);
      // alphabet swapped mid-string: remaining digits use base 16
      send_text("-12");
      program_alphabet(5'd16, 1'b0);
      send_text("F");
      send_byte(stoi_pkg::CHAR_NUL);

      // Random: one alphabet setting per phase, idle mixes rotating
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         case (p)
            0: begin fill_hex_digits(); len = 5'd10; end
            1: begin make_alphabet(16, FAULT_NONE); len = 5'd16; end
            2: begin
               make_alphabet(2, FAULT_NONE);
               alpha[0] = 8'd33;
               alpha[1] = 8'd127;
               len = 5'd2;
            end
            3: begin make_alphabet(16, FAULT_NONE); len = 5'd0; end
            4: begin make_alphabet(16, FAULT_NONE); len = 5'd1; end
            5: begin make_alphabet(16, FAULT_NONE); len = 5'd17; end
            6: begin
               for (int k = 0; k < 16; k++) alpha[k] = 8'($urandom_range(0, 255));
               len = 5'd31;
            end
            7, 8, 9, 10: begin
               len = 5'($urandom_range(2, 16));
               make_alphabet(int'(len), alphabet_fault_type'(p - 6));
            end
            default: begin
               len = 5'($urandom_range(2, 16));
               make_alphabet(int'(len), FAULT_NONE);
            end
         endcase
         program_alphabet(len, (p % 3) == 0);
         set_idle_mix(p % 4);
         target = bytes_sent + BYTES_PER_SETTING;
         while (bytes_sent < target) send_string(len);
      end

      // Drain the last results and watch for strays
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Parsed %0d strings from %0d bytes; %0d results checked.",
               strings_sent, bytes_sent, board.numbers_checked);
      $display("Covered %0d alphabet settings (valid, short, long, faulty) and four idle mixes.",
               NUM_SETTINGS + 2);
      if (board.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/stoi_pkg.sv
rtl/stoi_alphabet.sv
rtl/stoi_parser.sv
rtl/string_to_integer_any_base_unit.sv
rtl/stoi_checker.sv
test/tb_top.sv
